@@ hdl/union_find_spanning_tree_join_top_assert.svh @@
// Assertion macros for the spanning-tree join sequencer (ufj_ctrl).
`ifndef UNION_FIND_SPANNING_TREE_JOIN_TOP_ASSERT_SVH
`define UNION_FIND_SPANNING_TREE_JOIN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define UFJ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ufj: same-cycle check failed");
// Next-cycle implication under reset.
`define UFJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ufj: next-cycle check failed");
`else
`define UFJ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UFJ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/ufj_pkg.sv @@
// Shared types and constants for the spanning-tree join block.
`default_nettype none
package ufj_pkg;
  localparam int WEIGHT_W    = 32;
  localparam int NODE_W      = 10;
  localparam int TOTAL_W     = 48;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;
  // Widest node address and set size over the supported node counts
  localparam int NAW_MAX = 16;
  localparam int NSW_MAX = 17;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Memory command from the sequencer to the set store
  typedef struct packed {
    logic [NAW_MAX-1:0] par_raddr;
    logic               par_we;
    logic [NAW_MAX-1:0] par_waddr;
    logic [NAW_MAX-1:0] par_wdata;
    logic [NAW_MAX-1:0] sz_raddr;
    logic               sz_we;
    logic [NAW_MAX-1:0] sz_waddr;
    logic [NSW_MAX-1:0] sz_wdata;
  } mem_cmd_t;
endpackage
`default_nettype wire

@@ hdl/ufj_mem.sv @@
// Parent-link and set-size memories, one read and one write port each.
`default_nettype none
module ufj_mem #(
  parameter int NODE_COUNT = 1024
) (
  input  wire                          clk,
  input  wire  ufj_pkg::mem_cmd_t      cmd,
  output logic [ufj_pkg::NAW_MAX-1:0]  par_rdata,
  output logic [ufj_pkg::NSW_MAX-1:0]  sz_rdata
);
  import ufj_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SW = AW + 1;

  logic [AW-1:0] par_mem [NODE_COUNT];
  logic [SW-1:0] sz_mem  [NODE_COUNT];
  logic [AW-1:0] par_q_r;
  logic [SW-1:0] sz_q_r;

  // parent links: registered read
  always_ff @(posedge clk) begin
    if (cmd.par_we) begin
      par_mem[cmd.par_waddr[AW-1:0]] <= cmd.par_wdata[AW-1:0];
    end
    par_q_r <= par_mem[cmd.par_raddr[AW-1:0]];
  end

  // set sizes: registered read
  always_ff @(posedge clk) begin
    if (cmd.sz_we) begin
      sz_mem[cmd.sz_waddr[AW-1:0]] <= cmd.sz_wdata[SW-1:0];
    end
    sz_q_r <= sz_mem[cmd.sz_raddr[AW-1:0]];
  end

  assign par_rdata = NAW_MAX'(par_q_r);
  assign sz_rdata  = NSW_MAX'(sz_q_r);
endmodule
`default_nettype wire

@@ hdl/ufj_ctrl.sv @@
// Sequencer: root search with path compression, union by size, running total.
`default_nettype none
`include "union_find_spanning_tree_join_top_assert.svh"
module ufj_ctrl #(
  parameter int NODE_COUNT = 1024
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [ufj_pkg::WEIGHT_W-1:0]  in_weight,
  input  wire  [ufj_pkg::NODE_W-1:0]    in_a,
  input  wire  [ufj_pkg::NODE_W-1:0]    in_b,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_merged,
  output logic [ufj_pkg::TOTAL_W-1:0]   out_total,
  output logic [ufj_pkg::NODE_W-1:0]    out_root,
  output ufj_pkg::mem_cmd_t             mem_cmd,
  input  wire  [ufj_pkg::NAW_MAX-1:0]   par_rdata,
  input  wire  [ufj_pkg::NSW_MAX-1:0]   sz_rdata
);
  import ufj_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SW = AW + 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FIND_RD, ST_FIND_CHK, ST_CMP_RD, ST_CMP_CHK,
    ST_SZ_RD_A, ST_SZ_RD_B, ST_SZ_CHK, ST_FIN
  } state_t;

  state_t              st_r;
  logic [AW-1:0]       clr_idx_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [AW-1:0]       b_r;
  logic [AW-1:0]       cur_r;
  logic [AW-1:0]       start_r;
  logic [AW-1:0]       top_r;
  logic [AW-1:0]       ra_r;
  logic                side_r;
  logic [SW-1:0]       size_a_r;
  logic                res_merged_r;
  logic [AW-1:0]       res_root_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                out_valid_r;
  logic                out_merged_r;
  logic [TOTAL_W-1:0]  out_total_r;
  logic [NODE_W-1:0]   out_root_r;

  logic [AW-1:0]       par_q;
  logic [SW-1:0]       size_b;
  logic                a_oob;
  logic                b_oob;
  logic                b_bigger;
  logic [AW-1:0]       keep;
  logic [AW-1:0]       hang;
  logic [SW-1:0]       size_sum;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_nxt;
  logic                in_fire;
  logic                out_free;

  assign par_q    = par_rdata[AW-1:0];
  assign size_b   = sz_rdata[SW-1:0];
  assign a_oob    = (32'(in_a) >= NODE_COUNT);
  assign b_oob    = (32'(in_b) >= NODE_COUNT);
  assign in_ready = (st_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // union by size: ties keep the root of the first node
  assign b_bigger  = (size_a_r < size_b);
  assign keep      = b_bigger ? top_r : ra_r;
  assign hang      = b_bigger ? ra_r : top_r;
  assign size_sum  = size_a_r + size_b;
  assign total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(weight_r);
  assign total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  // memory command decode
  always_comb begin
    mem_cmd           = '0;
    mem_cmd.par_raddr = NAW_MAX'(cur_r);
    mem_cmd.sz_raddr  = (st_r == ST_SZ_RD_A) ? NAW_MAX'(ra_r) : NAW_MAX'(top_r);
    unique case (st_r)
      ST_CLEAR: begin
        mem_cmd.par_we    = 1'b1;
        mem_cmd.par_waddr = NAW_MAX'(clr_idx_r);
        mem_cmd.par_wdata = NAW_MAX'(clr_idx_r);
        mem_cmd.sz_we     = 1'b1;
        mem_cmd.sz_waddr  = NAW_MAX'(clr_idx_r);
        mem_cmd.sz_wdata  = NSW_MAX'(1);
      end
      ST_CMP_CHK: begin
        mem_cmd.par_we    = 1'b1;
        mem_cmd.par_waddr = NAW_MAX'(cur_r);
        mem_cmd.par_wdata = NAW_MAX'(top_r);
      end
      ST_SZ_CHK: begin
        mem_cmd.par_we    = 1'b1;
        mem_cmd.par_waddr = NAW_MAX'(hang);
        mem_cmd.par_wdata = NAW_MAX'(keep);
        mem_cmd.sz_we     = 1'b1;
        mem_cmd.sz_waddr  = NAW_MAX'(keep);
        mem_cmd.sz_wdata  = NSW_MAX'(size_sum);
      end
      default: begin
      end
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_idx_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the finishing state reloads the output register itself
      if (out_valid_r && out_ready && st_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        // sweep every entry back to a singleton
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == AW'(NODE_COUNT - 1)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            weight_r <= in_weight;
            b_r      <= AW'(in_b);
            cur_r    <= AW'(in_a);
            start_r  <= AW'(in_a);
            side_r   <= 1'b0;
            if (a_oob || b_oob) begin
              res_merged_r <= 1'b0;
              res_root_r   <= '0;
              st_r         <= ST_FIN;
            end else begin
              st_r <= ST_FIND_RD;
            end
          end
        end
        ST_FIND_RD: begin
          st_r <= ST_FIND_CHK;
        end
        // a node that links to itself is the root
        ST_FIND_CHK: begin
          if (par_q == cur_r) begin
            top_r <= cur_r;
            cur_r <= start_r;
            st_r  <= ST_CMP_RD;
          end else begin
            cur_r <= par_q;
            st_r  <= ST_FIND_RD;
          end
        end
        // compression walk ends at the root
        ST_CMP_RD: begin
          if (cur_r == top_r) begin
            if (!side_r) begin
              ra_r    <= top_r;
              side_r  <= 1'b1;
              cur_r   <= b_r;
              start_r <= b_r;
              st_r    <= ST_FIND_RD;
            end else if (ra_r == top_r) begin
              res_merged_r <= 1'b0;
              res_root_r   <= top_r;
              st_r         <= ST_FIN;
            end else begin
              st_r <= ST_SZ_RD_A;
            end
          end else begin
            st_r <= ST_CMP_CHK;
          end
        end
        ST_CMP_CHK: begin
          cur_r <= par_q;
          st_r  <= ST_CMP_RD;
        end
        ST_SZ_RD_A: begin
          st_r <= ST_SZ_RD_B;
        end
        ST_SZ_RD_B: begin
          size_a_r <= size_b;
          st_r     <= ST_SZ_CHK;
        end
        ST_SZ_CHK: begin
          total_r      <= total_nxt;
          res_merged_r <= 1'b1;
          res_root_r   <= keep;
          st_r         <= ST_FIN;
        end
        // hand the result to the output register once it is free
        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_merged_r <= res_merged_r;
            out_total_r  <= total_r;
            out_root_r   <= NODE_W'(res_root_r);
            st_r         <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_merged = out_merged_r;
  assign out_total  = out_total_r;
  assign out_root   = out_root_r;

  // one edge in flight: an accepted beat closes the input side next cycle
  `UFJ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_fire, !in_ready)
  // compression only rewrites nodes below the root
  `UFJ_ASSERT_NOW(a_cmp_below_root, clk, rst_n, st_r == ST_CMP_CHK, cur_r != top_r)
  // a link is only made between two different roots
  `UFJ_ASSERT_NOW(a_link_distinct, clk, rst_n, st_r == ST_SZ_CHK, ra_r != top_r)
  // the finished result never overwrites an untaken beat
  `UFJ_ASSERT_NEXT(a_fin_holds, clk, rst_n,
    st_r == ST_FIN && out_valid_r && !out_ready, st_r == ST_FIN)
endmodule
`default_nettype wire

@@ hdl/union_find_spanning_tree_join_top.sv @@
// Kruskal join stage: edges in, merge decision and running tree weight out.
// Usage:
//   Input channel in_*: one beat per graph edge (weight, node_a, node_b),
//   normally presented in ascending weight order. Output channel out_*: one
//   beat per edge with merged flag, saturating 48-bit tree weight and the
//   root of the set that now holds both endpoints.
//   Flow: out_tvalid rises once both root searches, each followed by path
//   compression of its search path, are done and, when the roots differ,
//   both set sizes have been read and the link and new size written; each
//   parent hop and each rewritten node passes through the registered read
//   of the parent-link memory. Edges are taken one at a time.
//   Edges with an endpoint not below NODE_COUNT leave all state alone and
//   return with merged = 0 and new_root = 0.
//   Reset: a clearing pass over all NODE_COUNT nodes makes each a singleton
//   of size one; in_tready stays low until it ends. The total resets to zero.
//   Stall: the result waits in an output register; the block accepts the
//   next edge meanwhile and holds its own result until the register frees.
`default_nettype none
module union_find_spanning_tree_join_top #(
  parameter int NODE_COUNT = 1024
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [31:0] edge_weight, [41:32] node_a, [51:42] node_b, [55:52] zero
  input  wire  [ufj_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [0] merged, [48:1] tree_weight, [58:49] new_root, [63:59] zero
  output logic [ufj_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ufj_pkg::*;

  mem_cmd_t            mem_cmd;
  logic [NAW_MAX-1:0]  par_rdata;
  logic [NSW_MAX-1:0]  sz_rdata;
  logic                out_merged;
  logic [TOTAL_W-1:0]  out_total;
  logic [NODE_W-1:0]   out_root;

  // sequencer
  ufj_ctrl #(
    .NODE_COUNT (NODE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_weight  (in_tdata[WEIGHT_W-1:0]),
    .in_a       (in_tdata[WEIGHT_W+NODE_W-1:WEIGHT_W]),
    .in_b       (in_tdata[WEIGHT_W+2*NODE_W-1:WEIGHT_W+NODE_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_merged (out_merged),
    .out_total  (out_total),
    .out_root   (out_root),
    .mem_cmd    (mem_cmd),
    .par_rdata  (par_rdata),
    .sz_rdata   (sz_rdata)
  );

  // disjoint-set store
  ufj_mem #(
    .NODE_COUNT (NODE_COUNT)
  ) u_mem (
    .clk       (clk),
    .cmd       (mem_cmd),
    .par_rdata (par_rdata),
    .sz_rdata  (sz_rdata)
  );

  // result beat packing
  assign out_tdata = {(OUT_TDATA_W - 1 - TOTAL_W - NODE_W)'(0), out_root, out_total,
                      out_merged};
endmodule
`default_nettype wire

@@ sim/ufj_join_checker.sv @@
// Stream checker for the spanning-tree join block: predicts each join and compares results.
`timescale 1ns / 100ps
module ufj_join_checker
  import ufj_pkg::*;
#(
  parameter int NODE_COUNT = 1024
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  input  wire                    in_tready,
  // [31:0] edge_weight, [41:32] node_a, [51:42] node_b, [55:52] zero
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  input  wire                    out_tvalid,
  input  wire                    out_tready,
  // [0] merged, [48:1] tree_weight, [58:49] new_root, [63:59] zero
  input  wire [OUT_TDATA_W-1:0]  out_tdata,
  output int unsigned            fail_count,
  output int unsigned            joins_pending,
  output int unsigned            results_seen
);

  typedef struct packed {
    logic               merged;
    logic [TOTAL_W-1:0] total;
    logic [NODE_W-1:0]  root;
  } join_result_t;

  // Disjoint-set shadow: parent link and set size per node, plus tree total
  int unsigned        leader_of [NODE_COUNT];
  int unsigned        members   [NODE_COUNT];
  logic [TOTAL_W-1:0] tree_total;
  join_result_t       expected_joins [$];
  join_result_t       want_join;
  join_result_t       next_join;

  // Root search with full path compression
  function automatic int unsigned find_leader(int unsigned node);
    int unsigned top;
    int unsigned walk;
    int unsigned up;
    top = node;
    while (leader_of[top] != top) top = leader_of[top];
    walk = node;
    while (walk != top) begin
      up = leader_of[walk];
      leader_of[walk] = top;
      walk = up;
    end
    return top;
  endfunction

  // Apply one edge to the shadow store and return the result it must produce
  function automatic join_result_t join_edge(logic [WEIGHT_W-1:0] weight,
                                             logic [NODE_W-1:0] node_a,
                                             logic [NODE_W-1:0] node_b);
    join_result_t res;
    int unsigned  ra;
    int unsigned  rb;
    int unsigned  keep;
    int unsigned  hang;
    res.merged = 1'b0;
    res.total  = tree_total;
    res.root   = '0;
    // out-of-range endpoint: state untouched, root reported as zero
    if (int'(node_a) >= NODE_COUNT || int'(node_b) >= NODE_COUNT) return res;
    ra = find_leader(32'(node_a));
    rb = find_leader(32'(node_b));
    // already connected (self loops land here too)
    if (ra == rb) begin
      res.root = NODE_W'(ra);
      return res;
    end
    if (tree_total > TOTAL_MAX - TOTAL_W'(weight)) tree_total = TOTAL_MAX;
    else tree_total = tree_total + TOTAL_W'(weight);
    // union by size, ties keep node_a's root
    keep = ra;
    hang = rb;
    if (members[ra] < members[rb]) begin
      keep = rb;
      hang = ra;
    end
    members[keep] = members[keep] + members[hang];
    leader_of[hang] = keep;
    res.merged = 1'b1;
    res.total  = tree_total;
    res.root   = NODE_W'(keep);
    return res;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: result beat %0d, %s got 0x%0h, want 0x%0h",
             $time, results_seen, field, got, want);
    fail_count++;
  endtask

  // Edge beats feed the predictor; result beats are checked in order
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        leader_of[n] = n;
        members[n]   = 1;
      end
      tree_total = '0;
      expected_joins.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        next_join = join_edge(in_tdata[31:0], in_tdata[41:32], in_tdata[51:42]);
        expected_joins = {expected_joins, next_join};
      end
      if (out_tvalid && out_tready) begin
        if (expected_joins.size() == 0) begin
          report("unexpected beat", out_tdata, '0);
        end else begin
          want_join = expected_joins.pop_front();
          if (out_tdata[0] !== want_join.merged)
            report("merged", 64'(out_tdata[0]), 64'(want_join.merged));
          if (out_tdata[48:1] !== want_join.total)
            report("tree_weight", 64'(out_tdata[48:1]), 64'(want_join.total));
          if (out_tdata[58:49] !== want_join.root)
            report("new_root", 64'(out_tdata[58:49]), 64'(want_join.root));
          if (out_tdata[63:59] !== 5'b0)
            report("padding", 64'(out_tdata[63:59]), 64'(0));
        end
        results_seen++;
      end
    end
    joins_pending = expected_joins.size();
  end

endmodule

@@ sim/tb_union_find_spanning_tree_join_top.sv @@
// Testbench top for the spanning-tree join block: clock, reset, edge stimulus and verdict.
`timescale 1ns / 100ps
module tb_union_find_spanning_tree_join_top;
  import ufj_pkg::*;

  localparam int          NODES       = 1024;
  localparam int          RANDOM_EDGES = 1050;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  wire                    in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  wire                    out_tvalid;
  logic                   out_tready;
  wire  [OUT_TDATA_W-1:0] out_tdata;

  int unsigned fail_count;
  int unsigned joins_pending;
  int unsigned results_seen;
  int unsigned cycles = 0;
  bit          tx_gaps = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  union_find_spanning_tree_join_top #(
    .NODE_COUNT(NODES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  ufj_join_checker #(
    .NODE_COUNT(NODES)
  ) join_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .joins_pending(joins_pending),
    .results_seen (results_seen)
  );

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one edge beat, with random gaps ahead of it while tx_gaps is set; returns on a falling edge
  task automatic send_edge(logic [WEIGHT_W-1:0] weight, logic [NODE_W-1:0] node_a,
                           logic [NODE_W-1:0] node_b);
    while (tx_gaps && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 52){1'b0}}, node_b, node_a, weight};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!held && results_seen >= 150) begin
        held       = 1'b1;
        hold_left  = 600;
        out_tready <= 1'b0;
      end else if (results_seen >= 700 && results_seen < 900) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Edge stimulus and verdict
  initial begin
    logic [WEIGHT_W-1:0] wcur;
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] step;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [NODE_W-1:0]   prev_a;
    logic [NODE_W-1:0]   prev_b;
    int unsigned         pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ties, size order, self loops, extreme weights and indexes
    send_edge(32'd0, 10'd0, 10'd1);            // tie, node_a's root stays
    send_edge(32'd1, 10'd1023, 10'd1022);
    send_edge(32'd2, 10'd5, 10'd5);            // self loop
    send_edge(32'd3, 10'd1, 10'd0);            // already joined
    send_edge(32'd4, 10'd2, 10'd0);            // smaller set hangs under larger
    send_edge(32'd5, 10'd1022, 10'd3);
    send_edge(32'd6, 10'd4, 10'd1023);
    send_edge(32'd7, 10'd0, 10'd1023);         // root 0 goes under 1023
    send_edge(32'd8, 10'd2, 10'd1);            // deep find, compresses
    send_edge(32'hFFFF_FFFF, 10'd6, 10'd7);
    send_edge(32'hFFFF_FFFF, 10'd7, 10'd1022);
    send_edge(32'd0, 10'd8, 10'd9);            // zero weight, out of order
    send_edge(32'd9, 10'd1023, 10'd1023);
    // build a three-level tree, then walk it from the bottom
    send_edge(32'd10, 10'd20, 10'd21);
    send_edge(32'd11, 10'd22, 10'd23);
    send_edge(32'd12, 10'd20, 10'd22);
    send_edge(32'd13, 10'd24, 10'd25);
    send_edge(32'd14, 10'd26, 10'd27);
    send_edge(32'd15, 10'd24, 10'd26);
    send_edge(32'd16, 10'd20, 10'd24);
    send_edge(32'd17, 10'd27, 10'd23);
    send_edge(32'd18, 10'd25, 10'd21);
    send_edge(32'hAAAA_AAAA, 10'h2AA, 10'h155);
    send_edge(32'h5555_5555, 10'h155, 10'd9);

    // Random: mostly ascending weights, mix of wide, local, self-loop and repeat edges
    wcur   = $urandom_range(0, 1000);
    prev_a = 10'd0;
    prev_b = 10'd1;
    for (int i = 0; i < RANDOM_EDGES; i++) begin
      tx_gaps = !(i >= 400 && i < 600);
      if ($urandom_range(0, 99) < 12) begin
        weight = $urandom();
      end else begin
        step = $urandom_range(0, 32'h0040_0000);
        if (wcur > 32'hFFFF_FFFF - step) wcur = $urandom_range(0, 255);
        else wcur = wcur + step;
        weight = wcur;
      end
      pick   = $urandom_range(0, 99);
      node_a = NODE_W'($urandom_range(0, NODES - 1));
      if (pick < 45) begin
        node_b = NODE_W'($urandom_range(0, NODES - 1));
      end else if (pick < 80) begin
        node_b = node_a ^ NODE_W'($urandom_range(1, 15));
      end else if (pick < 88) begin
        node_b = node_a;
      end else begin
        node_a = prev_b;
        node_b = prev_a;
      end
      send_edge(weight, node_a, node_b);
      prev_a = node_a;
      prev_b = node_b;
    end
    in_tvalid <= 1'b0;

    wait (joins_pending == 0);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ufj_pkg.sv
hdl/ufj_mem.sv
hdl/ufj_ctrl.sv
hdl/union_find_spanning_tree_join_top.sv
sim/ufj_join_checker.sv
sim/tb_union_find_spanning_tree_join_top.sv
